>>> sv/lfrs_pkg.sv
`default_nettype none

package lfrs_pkg;

    // Field widths fixed by the item format
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 24;
    localparam int ROOM_OUT_W = 4;
    localparam int CFG_W      = 5;

    // Room index and room count widths cover the largest supported row (128 rooms)
    localparam int ROOM_IDX_W = 7;
    localparam int ROOM_CNT_W = 8;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);

    // Scan record handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic [TIME_W-1:0]     start;
        logic [TIME_W-1:0]     dur;
        logic                  found;
        logic [ROOM_IDX_W-1:0] free_idx;
        logic [COUNT_W-1:0]    free_cnt;
        logic                  min_ok;
        logic [TIME_W-1:0]     min_val;
        logic [ROOM_IDX_W-1:0] min_idx;
        logic [COUNT_W-1:0]    min_cnt;
    } t_wave;

    // Write-back broadcast to the row
    typedef struct packed {
        logic                  valid;
        logic [ROOM_IDX_W-1:0] idx;
        logic [TIME_W-1:0]     free_at;
        logic [COUNT_W-1:0]    count;
    } t_upd;

endpackage

`default_nettype wire

>>> sv/lowest_free_room_scheduler.sv
`default_nettype none

// Channel  Direction  Handshake                       Payload
// in       input      i_in_valid / o_in_ready         i_start_time, i_finish_time
// out      output     o_out_valid / i_out_ready       o_room, o_actual_start, o_actual_finish,
//                                                     o_delayed, o_most_booked_room,
//                                                     o_most_booked_count
// cfg      input      i_cfg_valid / o_cfg_ready       i_cfg_rooms_in_use
//
// A result passes through one register per room cell and the hold register, then commits
// into the output register.
// A new item is accepted the cycle after the previous one commits; a result waiting in the
// output register stalls the next commit, and with it the next acceptance.
// Reset (synchronous, active low) clears all room times and counts and sets the room count
// to 16. Configuration writes are always ready.

module lowest_free_room_scheduler #(
    parameter int NUM_ROOMS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lfrs_pkg::CFG_W-1:0]          i_cfg_rooms_in_use,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [lfrs_pkg::TIME_W-1:0]         i_start_time,
    input  wire logic [lfrs_pkg::TIME_W-1:0]         i_finish_time,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [lfrs_pkg::ROOM_OUT_W-1:0]          o_room,
    output logic [lfrs_pkg::TIME_W-1:0]              o_actual_start,
    output logic [lfrs_pkg::TIME_W-1:0]              o_actual_finish,
    output logic                                     o_delayed,
    output logic [lfrs_pkg::ROOM_OUT_W-1:0]          o_most_booked_room,
    output logic [lfrs_pkg::COUNT_W-1:0]             o_most_booked_count
);

    lfrs_pkg::t_wave                     wave [NUM_ROOMS+1];
    logic [NUM_ROOMS:0]                  wave_valids;
    lfrs_pkg::t_upd                      upd;

    logic [lfrs_pkg::CFG_W-1:0]          r_cfg;
    logic [lfrs_pkg::ROOM_CNT_W-1:0]     eff_rooms;
    logic                                r_busy;
    logic                                accept;
    lfrs_pkg::t_wave                     r_hold;
    logic                                r_hold_v;
    logic                                commit;

    logic [lfrs_pkg::ROOM_IDX_W-1:0]     pick;
    logic [lfrs_pkg::TIME_W-1:0]         begin_t;
    logic [lfrs_pkg::TIME_W:0]           sum;
    logic [lfrs_pkg::TIME_W-1:0]         end_t;
    logic [lfrs_pkg::COUNT_W-1:0]        old_cnt;
    logic [lfrs_pkg::COUNT_W-1:0]        new_cnt;
    logic                                take_best;

    logic [lfrs_pkg::ROOM_IDX_W-1:0]     r_best_room;
    logic [lfrs_pkg::COUNT_W-1:0]        r_best_cnt;
    logic [lfrs_pkg::ROOM_OUT_W-1:0]     r_room;
    logic [lfrs_pkg::TIME_W-1:0]         r_start;
    logic [lfrs_pkg::TIME_W-1:0]         r_finish;
    logic                                r_delayed;
    logic                                r_out_valid;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lfrs_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_rooms_in_use;
        end
    end

    // Clamp the room count to one through NUM_ROOMS
    always_comb begin
        if (r_cfg == '0) begin
            eff_rooms = lfrs_pkg::ROOM_CNT_W'(1);
        end else if (32'(r_cfg) > 32'(NUM_ROOMS)) begin
            eff_rooms = lfrs_pkg::ROOM_CNT_W'(NUM_ROOMS);
        end else begin
            eff_rooms = lfrs_pkg::ROOM_CNT_W'(r_cfg);
        end
    end

    // Inject a fresh scan record on acceptance
    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        wave[0]       = '0;
        wave[0].valid = accept;
        wave[0].start = i_start_time;
        wave[0].dur   = (i_finish_time > i_start_time) ? (i_finish_time - i_start_time) : '0;
    end

    // Row of room cells
    for (genvar g = 0; g < NUM_ROOMS; g++) begin : g_cell
        lfrs_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rooms (eff_rooms),
            .i_wave  (wave[g]),
            .i_upd   (upd),
            .o_wave  (wave[g+1])
        );
    end

    for (genvar g = 0; g <= NUM_ROOMS; g++) begin : g_valids
        assign wave_valids[g] = wave[g].valid;
    end

    // Hold the finished scan until the output register is free
    assign commit = r_hold_v && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (wave[NUM_ROOMS].valid) begin
            r_hold <= wave[NUM_ROOMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            if (wave[NUM_ROOMS].valid) begin
                r_hold_v <= 1'b1;
            end else if (commit) begin
                r_hold_v <= 1'b0;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Resolve the assignment and the saturating end tick
    always_comb begin
        pick    = r_hold.found ? r_hold.free_idx : r_hold.min_idx;
        begin_t = r_hold.found ? r_hold.start    : r_hold.min_val;
        old_cnt = r_hold.found ? r_hold.free_cnt : r_hold.min_cnt;
        sum     = {1'b0, begin_t} + {1'b0, r_hold.dur};
        end_t   = sum[lfrs_pkg::TIME_W] ? lfrs_pkg::TIME_MAX : sum[lfrs_pkg::TIME_W-1:0];
        new_cnt = (old_cnt == lfrs_pkg::COUNT_MAX) ? old_cnt : (old_cnt + 1'b1);
    end

    // Only the picked room's count moves, so compare it against the running best
    assign take_best = (new_cnt > r_best_cnt) ||
                       ((new_cnt == r_best_cnt) && (pick < r_best_room));

    always_comb begin
        upd.valid   = commit;
        upd.idx     = pick;
        upd.free_at = end_t;
        upd.count   = new_cnt;
    end

    // Best-room tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_room <= '0;
            r_best_cnt  <= '0;
        end else if (commit && take_best) begin
            r_best_room <= pick;
            r_best_cnt  <= new_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_room    <= pick[lfrs_pkg::ROOM_OUT_W-1:0];
            r_start   <= begin_t;
            r_finish  <= end_t;
            r_delayed <= !r_hold.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_room              = r_room;
    assign o_actual_start      = r_start;
    assign o_actual_finish     = r_finish;
    assign o_delayed           = r_delayed;
    assign o_most_booked_room  = r_best_room[lfrs_pkg::ROOM_OUT_W-1:0];
    assign o_most_booked_count = r_best_cnt;

`ifndef SYNTHESIS
    a_one_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wave_valids))
        else $error("more than one scan record in the room row");

    a_hold_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wave[NUM_ROOMS].valid |-> !r_hold_v)
        else $error("scan finished while the previous one is still held");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_busy)
        else $error("held scan without an item in flight");

    a_pick_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (lfrs_pkg::ROOM_CNT_W'(pick) < eff_rooms))
        else $error("booking assigned to an inactive room");
`endif

endmodule

`default_nettype wire

>>> sv/lfrs_cell.sv
`default_nettype none

module lfrs_cell #(
    parameter int IDX = 0
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [lfrs_pkg::ROOM_CNT_W-1:0]     i_rooms,
    input  wire lfrs_pkg::t_wave                     i_wave,
    input  wire lfrs_pkg::t_upd                      i_upd,
    output lfrs_pkg::t_wave                          o_wave
);

    localparam logic [lfrs_pkg::ROOM_IDX_W-1:0] MY_IDX = lfrs_pkg::ROOM_IDX_W'(IDX);
    localparam logic [lfrs_pkg::ROOM_CNT_W-1:0] MY_POS = lfrs_pkg::ROOM_CNT_W'(IDX);

    logic [lfrs_pkg::TIME_W-1:0]  r_free_at;
    logic [lfrs_pkg::COUNT_W-1:0] r_count;
    lfrs_pkg::t_wave              r_wave;
    lfrs_pkg::t_wave              n_wave;
    logic                         active;

    assign active = (MY_POS < i_rooms);

    // Fold this room into the passing record
    always_comb begin
        n_wave = i_wave;
        if (active) begin
            if (!i_wave.found && (r_free_at <= i_wave.start)) begin
                n_wave.found    = 1'b1;
                n_wave.free_idx = MY_IDX;
                n_wave.free_cnt = r_count;
            end
            if (!i_wave.min_ok || (r_free_at < i_wave.min_val)) begin
                n_wave.min_ok  = 1'b1;
                n_wave.min_val = r_free_at;
                n_wave.min_idx = MY_IDX;
                n_wave.min_cnt = r_count;
            end
        end
    end

    // Hand the record to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
    end

    // Take the write-back addressed to this room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_at <= '0;
            r_count   <= '0;
        end else if (i_upd.valid && (i_upd.idx == MY_IDX)) begin
            r_free_at <= i_upd.free_at;
            r_count   <= i_upd.count;
        end
    end

    assign o_wave = r_wave;

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROOMS       = 16;
    localparam int SCAN_CYCLES = ROOMS + 2;
    localparam int IDLE_PCT    = 12;

    typedef logic [lfrs_pkg::TIME_W-1:0] t_tick;

    typedef struct packed {
        logic [lfrs_pkg::ROOM_OUT_W-1:0] room;
        t_tick                           actual_start;
        t_tick                           actual_finish;
        logic                            delayed;
        logic [lfrs_pkg::ROOM_OUT_W-1:0] top_room;
        logic [lfrs_pkg::COUNT_W-1:0]    top_count;
    } t_booking;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lfrs_pkg::CFG_W-1:0]      cfg_rooms = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    t_tick                           in_start  = '0;
    t_tick                           in_finish = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [lfrs_pkg::ROOM_OUT_W-1:0] out_room;
    t_tick                           out_start;
    t_tick                           out_finish;
    logic                            out_delayed;
    logic [lfrs_pkg::ROOM_OUT_W-1:0] out_top_room;
    logic [lfrs_pkg::COUNT_W-1:0]    out_top_count;

    // Scheduler state as the block should hold it
    t_tick                        room_free  [ROOMS] = '{default: '0};
    logic [lfrs_pkg::COUNT_W-1:0] room_count [ROOMS] = '{default: '0};
    logic [lfrs_pkg::CFG_W-1:0]   rooms_cfg          = lfrs_pkg::CFG_RESET;

    t_booking booked_q[$];
    int       errors    = 0;
    int       idle_pct  = IDLE_PCT;
    int       stall_pct = IDLE_PCT;
    t_tick    now_tick  = '0;

    lowest_free_room_scheduler #(
        .NUM_ROOMS(ROOMS)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_rooms_in_use (cfg_rooms),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_start_time       (in_start),
        .i_finish_time      (in_finish),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_room             (out_room),
        .o_actual_start     (out_start),
        .o_actual_finish    (out_finish),
        .o_delayed          (out_delayed),
        .o_most_booked_room (out_top_room),
        .o_most_booked_count(out_top_count)
    );

    always #4 clk = ~clk;

    // Assign one request to a room and update the room times and counts
    function automatic t_booking book_request(input t_tick s, input t_tick f);
        t_booking                  r;
        t_tick                     dur;
        logic [lfrs_pkg::TIME_W:0] sum;
        int                        n;
        int                        pick;
        bit                        found;
        dur = (f > s) ? f - s : '0;
        n = (rooms_cfg == 0) ? 1 : ((rooms_cfg > ROOMS) ? ROOMS : int'(rooms_cfg));
        found = 1'b0;
        pick = 0;
        // lowest free room first
        for (int i = 0; i < n; i++) begin
            if (!found && room_free[i] <= s) begin
                pick = i;
                found = 1'b1;
            end
        end
        // otherwise the earliest to free, lowest index on ties
        if (!found) begin
            for (int i = 1; i < n; i++) begin
                if (room_free[i] < room_free[pick])
                    pick = i;
            end
        end
        r.delayed = !found;
        r.actual_start = found ? s : room_free[pick];
        sum = {1'b0, r.actual_start} + {1'b0, dur};
        r.actual_finish = sum[lfrs_pkg::TIME_W] ? lfrs_pkg::TIME_MAX
                                                : sum[lfrs_pkg::TIME_W-1:0];
        room_free[pick] = r.actual_finish;
        if (room_count[pick] != lfrs_pkg::COUNT_MAX)
            room_count[pick]++;
        r.room = lfrs_pkg::ROOM_OUT_W'(pick);
        // most-booked scan over every room, active or not
        r.top_room = '0;
        r.top_count = room_count[0];
        for (int i = 1; i < ROOMS; i++) begin
            if (room_count[i] > r.top_count) begin
                r.top_count = room_count[i];
                r.top_room = lfrs_pkg::ROOM_OUT_W'(i);
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input t_tick exp_v, input t_tick got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
        end
    endtask

    // Compare each accepted result with the oldest booking, then pick the next ready
    always @(posedge clk) begin : result_check
        t_booking want;
        if (rst_n && out_valid && out_ready) begin
            if (booked_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got room %0d",
                         $time, out_room);
            end else begin
                want = booked_q.pop_front();
                check_field("room", t_tick'(want.room), t_tick'(out_room));
                check_field("actual_start", want.actual_start, out_start);
                check_field("actual_finish", want.actual_finish, out_finish);
                check_field("delayed", t_tick'(want.delayed), t_tick'(out_delayed));
                check_field("most_booked_room", t_tick'(want.top_room), t_tick'(out_top_room));
                check_field("most_booked_count", t_tick'(want.top_count),
                            t_tick'(out_top_count));
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one request, hold it until accepted, and record its booking
    task automatic send_request(input t_tick s, input t_tick f);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_start <= s;
        in_finish <= f;
        do @(posedge clk); while (!in_ready);
        booked_q.push_back(book_request(s, f));
    endtask

    // Drop valid, drain every outstanding booking, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (booked_q.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rooms(input logic [lfrs_pkg::CFG_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_rooms <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rooms_cfg = v;
    endtask

    // Reset room count: fill from room 0, zero and negative durations
    task automatic test_default_rooms();
        send_request(32'd0, 32'd10);
        send_request(32'd0, 32'd10);
        send_request(32'd5, 32'd5);
        send_request(32'd7, 32'd3);
        send_request(32'd10, 32'd12);
        settle();
    endtask

    // Room count of zero acts as one, counts above the row clamp to the row
    task automatic test_room_count_limits();
        write_rooms(lfrs_pkg::CFG_W'(0));
        send_request(32'd20, 32'd30);
        send_request(32'd21, 32'd25);
        write_rooms(lfrs_pkg::CFG_W'(31));
        send_request(32'd22, 32'd23);
        write_rooms(lfrs_pkg::CFG_W'(17));
        send_request(32'd22, 32'd40);
        write_rooms(lfrs_pkg::CFG_W'(1));
        send_request(32'd30, 32'd31);
        settle();
    endtask

    // Equal free times go to the lowest room; a start out of order still books
    task automatic test_delay_ties();
        write_rooms(lfrs_pkg::CFG_W'(3));
        send_request(32'd100, 32'd200);
        send_request(32'd100, 32'd200);
        send_request(32'd100, 32'd200);
        send_request(32'd150, 32'd160);
        send_request(32'd150, 32'd160);
        send_request(32'd90, 32'd95);
        send_request(32'd205, 32'd206);
        settle();
    endtask

    // Bookings near the top of the time range saturate their finish
    task automatic test_time_saturation();
        write_rooms(lfrs_pkg::CFG_W'(2));
        send_request(32'hFFFF_FF00, 32'hFFFF_FFF0);
        send_request(32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FF10, 32'hFFFF_FF80);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        settle();
    endtask

    // Rising starts with load near the room count, some out of order or malformed
    task automatic test_random_schedule(input logic [lfrs_pkg::CFG_W-1:0] rooms,
                                        input int items);
        t_tick s;
        t_tick f;
        int    span;
        write_rooms(rooms);
        span = 16 * ((rooms == 0) ? 1 : ((rooms > ROOMS) ? ROOMS : int'(rooms)));
        repeat (items) begin
            now_tick += $urandom_range(20);
            s = now_tick;
            if ($urandom_range(99) < 4)
                s = now_tick - $urandom_range(50);
            case ($urandom_range(19))
                0: f = s;
                1: f = s - $urandom_range(1, 100);
                default: f = s + $urandom_range(1, span);
            endcase
            send_request(s, f);
        end
        settle();
    endtask

    // Full-range times to toggle every bit of both fields
    task automatic test_random_fields(input int items);
        t_tick s;
        write_rooms(lfrs_pkg::CFG_W'(ROOMS));
        repeat (items) begin
            s = $urandom;
            send_request(s, $urandom_range(1) ? t_tick'($urandom) : s + $urandom_range(1000));
        end
        settle();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_rooms();
        test_room_count_limits();
        test_delay_ties();
        now_tick = 32'd1000;
        test_random_schedule(lfrs_pkg::CFG_W'(1), 200);
        test_random_schedule(lfrs_pkg::CFG_W'(3), 300);
        // long stretch with neither side idling
        idle_pct = 0;
        stall_pct = 0;
        test_random_schedule(lfrs_pkg::CFG_W'(16), 400);
        idle_pct = IDLE_PCT;
        stall_pct = IDLE_PCT;
        test_random_schedule(lfrs_pkg::CFG_W'(7), 300);
        test_random_schedule(lfrs_pkg::CFG_W'(0), 100);
        test_random_schedule(lfrs_pkg::CFG_W'(31), 150);
        test_time_saturation();
        test_random_fields(150);
        if (errors == 0 && booked_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
sv/lfrs_pkg.sv
sv/lfrs_cell.sv
sv/lowest_free_room_scheduler.sv
verif/tb.sv
